/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of the text console writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_BLANK   = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd15;

    localparam int CELL_W = 16;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [7:0]           char_code;
        logic [CUR_ROW_W-1:0] read_row;
        logic [CUR_COL_W-1:0] read_column;
    } t_cmd;

    typedef struct packed {
        logic [CUR_ROW_W-1:0] cursor_row_out;
        logic [CUR_COL_W-1:0] cursor_column_out;
        logic                 scrolled;
        logic [7:0]           cell_char;
        logic [7:0]           cell_color;
    } t_result;

endpackage

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Single-port-write, single-port-read screen store with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor, attribute register and sequencer for writes, reads, scroll and clear.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  tcw_pkg::t_cmd            i_cmd,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [7:0]               i_cfg_data,
    output logic                     o_done,
    output tcw_pkg::t_result         o_result,
    output logic                     o_rd_en,
    output logic [ADDR_W-1:0]        o_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_rd_data,
    output logic                     o_wr_en,
    output logic [ADDR_W-1:0]        o_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_wr_data
);

    import tcw_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_END    = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(COPY_N - 1);
    localparam logic [ADDR_W-1:0] TOTAL_LAST = ADDR_W'(TOTAL - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [7:0]        r_color;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_scr, n_scr;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_char, n_char;
    logic              r_done;
    t_result           r_result, n_result;

    logic              emit;
    logic              emit_scr;
    logic [CELL_W-1:0] emit_cell;
    logic              in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] req_addr;
    logic [CELL_W-1:0] blank_cell;

    assign blank_cell = {r_color, CHAR_BLANK};
    assign cur_addr   = ADDR_W'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));
    assign req_addr   = ADDR_W'(32'(i_cmd.read_row) * 32'(COLUMNS) + 32'(i_cmd.read_column));
    assign in_range   = (32'(i_cmd.read_row) < ROWS) && (32'(i_cmd.read_column) < COLUMNS);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_scr     = r_scr;
        n_rd_ok   = r_rd_ok;
        n_char    = r_char;
        emit      = 1'b0;
        emit_scr  = 1'b0;
        emit_cell = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.opcode)
                        OP_WRITE: begin
                            n_char = i_cmd.char_code;
                            n_scr  = 1'b0;
                            if (i_cmd.char_code == CHAR_NEWLINE || r_col == COL_END) begin
                                n_col = '0;
                                if (r_row != LAST_ROW) begin
                                    n_row = r_row + 1'b1;
                                    if (i_cmd.char_code == CHAR_NEWLINE) begin
                                        emit = 1'b1;
                                    end else begin
                                        n_state = S_WRITE;
                                    end
                                end else begin
                                    n_pend    = (i_cmd.char_code != CHAR_NEWLINE);
                                    n_scr     = 1'b1;
                                    n_idx     = '0;
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = ADDR_W'(COLUMNS);
                                    n_state   = S_COPY;
                                end
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                        OP_CLEAR: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_scr   = 1'b0;
                            n_state = S_BLANK;
                        end
                        OP_READ: begin
                            n_rd_ok   = in_range;
                            o_rd_en   = in_range;
                            o_rd_addr = req_addr;
                            n_state   = S_RDATA;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = cur_addr;
                o_wr_data = {r_color, r_char};
                n_col     = r_col + 1'b1;
                emit      = 1'b1;
                emit_scr  = r_scr;
                n_state   = S_IDLE;
            end
            S_RDATA: begin
                emit      = 1'b1;
                emit_cell = r_rd_ok ? i_rd_data : '0;
                n_state   = S_IDLE;
            end
            S_COPY: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = i_rd_data;
                if (r_idx == COPY_LAST) begin
                    n_idx   = ADDR_W'(COPY_N);
                    n_state = S_BLANK;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    o_rd_en   = 1'b1;
                    o_rd_addr = ADDR_W'(32'(r_idx) + COLUMNS + 1);
                end
            end
            S_BLANK: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = blank_cell;
                if (r_idx == TOTAL_LAST) begin
                    if (r_pend) begin
                        n_state = S_WRITE;
                    end else begin
                        emit     = 1'b1;
                        emit_scr = r_scr;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_result                   = r_result;
        n_result.cursor_row_out    = CUR_ROW_W'(n_row);
        n_result.cursor_column_out = CUR_COL_W'(n_col);
        n_result.scrolled          = emit_scr;
        n_result.cell_char         = emit_cell[7:0];
        n_result.cell_color        = emit_cell[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= COLOR_RESET;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_scr   <= 1'b0;
            r_rd_ok <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_done  <= emit;
            r_pend  <= n_pend;
            r_scr   <= n_scr;
            r_rd_ok <= n_rd_ok;
            r_idx   <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        if (emit) begin
            r_result <= n_result;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;

endmodule

/* rtl/text_console_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: a ROWS x COLUMNS cell screen store with a cursor.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. Each item gives
// exactly one result, shown on o_result for one cycle while o_done is high.
// The receiver cannot stall, so results are never held back.
// A character write passes through S_WRITE and a cell read through S_RDATA, where
// the registered read data of the screen memory is taken into the registered result.
// A newline that does not scroll, or an unused opcode, gives its result in the cycle
// after acceptance.
// Clear walks the whole memory one cell per cycle.
// A scroll copies rows up and blanks the bottom row one cell per cycle, and then
// writes the pending character if the item was not a newline.
// busy stays high while a write, read, clear or scroll is in progress.
// The attribute register is written through i_cfg_valid / o_cfg_ready while idle.
// Reset puts the cursor at row 0, column 0 and the attribute at 15. The screen
// memory is not cleared by reset; a cell must be written or cleared before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_cmd    i_cmd,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    output logic             o_done,
    output tcw_pkg::t_result o_result
);

    import tcw_pkg::*;

    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;

    tcw_ram #(
        .DEPTH(ROWS * COLUMNS),
        .WIDTH(CELL_W),
        .AW   (ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    tcw_ctrl #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    `TCW_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done)
    `TCW_ASSERT_IMPLY(a_scroll_last_row, i_clk, i_rst_n, o_done && o_result.scrolled,
        o_result.cursor_row_out == CUR_ROW_W'(ROWS - 1))
    `TCW_ASSERT_IMPLY(a_scroll_no_cell, i_clk, i_rst_n, o_done && o_result.scrolled,
        o_result.cell_char == 8'd0 && o_result.cell_color == 8'd0)

endmodule

/* tb/text_console_writer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking testbench for the text console writer.
// ----------------------------------------------------------------------------
// A short table of commands covers the reset state, the extremes of the fields,
// reads out of range and the unused opcode. Random traffic follows: lines of
// text, runs of newlines that wrap and scroll the screen, cell reads, clears
// and noise. Every item is also applied to a behavioral copy of the console,
// and each result strobe is compared with the oldest expected status. The
// attribute register is rewritten between phases while the console is idle.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int ROWS = DEF_ROWS;
    localparam int COLS = DEF_COLUMNS;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIR_ROWS = 21;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 115;

    typedef struct {
        t_cmd    cmd;
        logic    fixed_exp;
        t_result want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_cmd       i_cmd = '0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;
    logic       o_done;
    t_result    o_result;

    logic [15:0] screen_mem [ROWS*COLS];
    int          crs_row;
    int          crs_col;
    logic [7:0]  text_attr;

    t_result     expected_status_q [$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          sender_idle_pct = 0;
    t_dir_row    dir_tab [DIR_ROWS];

    text_console_writer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void blank_line(input int r);
        for (int c = 0; c < COLS; c++) begin
            screen_mem[r*COLS + c] = {text_attr, CHAR_BLANK};
        end
    endfunction

    function automatic logic line_feed();
        crs_col = 0;
        if (crs_row + 1 < ROWS) begin
            crs_row++;
            return 1'b0;
        end
        for (int i = 0; i < (ROWS-1)*COLS; i++) begin
            screen_mem[i] = screen_mem[i + COLS];
        end
        blank_line(ROWS-1);
        crs_row = ROWS-1;
        return 1'b1;
    endfunction

    function automatic t_result console_step(input t_cmd c);
        t_result r;
        r = '0;
        case (c.opcode)
            OP_WRITE: begin
                if (c.char_code == CHAR_NEWLINE) begin
                    r.scrolled = line_feed();
                end else begin
                    if (crs_col >= COLS) begin
                        r.scrolled = line_feed();
                    end
                    screen_mem[crs_row*COLS + crs_col] = {text_attr, c.char_code};
                    crs_col++;
                end
            end
            OP_CLEAR: begin
                for (int rw = 0; rw < ROWS; rw++) begin
                    blank_line(rw);
                end
            end
            OP_READ: begin
                if (c.read_row < ROWS && c.read_column < COLS) begin
                    r.cell_char  = screen_mem[c.read_row*COLS + c.read_column][7:0];
                    r.cell_color = screen_mem[c.read_row*COLS + c.read_column][15:8];
                end
            end
            default: begin
            end
        endcase
        r.cursor_row_out    = CUR_ROW_W'(crs_row);
        r.cursor_column_out = CUR_COL_W'(crs_col);
        return r;
    endfunction

    function automatic t_cmd random_cmd(input logic [1:0] op);
        t_cmd c;
        c.opcode      = op;
        c.char_code   = 8'($urandom);
        c.read_row    = CUR_ROW_W'($urandom);
        c.read_column = CUR_COL_W'($urandom);
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c, input logic fixed_exp, input t_result want);
        t_result model_res;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        model_res = console_step(c);
        expected_status_q.push_back(fixed_exp ? want : model_res);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain_results();
        while (expected_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        text_attr = v;
    endtask

    task automatic run_phase(input int n_items);
        int   sent;
        int   len;
        int   sel;
        t_cmd c;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                if ($urandom_range(4) == 0) begin
                    len = COLS - crs_col;
                end else if ($urandom_range(4) == 0) begin
                    len = $urandom_range(70, 90);
                end else begin
                    len = $urandom_range(1, 20);
                end
                for (int i = 0; i < len; i++) begin
                    c = random_cmd(OP_WRITE);
                    if (c.char_code == CHAR_NEWLINE) begin
                        c.char_code = CHAR_BLANK;
                    end
                    send_cmd(c, 1'b0, '0);
                end
                sent += len;
            end else if (sel < 52) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    c = random_cmd(OP_WRITE);
                    c.char_code = CHAR_NEWLINE;
                    send_cmd(c, 1'b0, '0);
                end
                sent += len;
            end else if (sel < 80) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    c = random_cmd(OP_READ);
                    if ($urandom_range(9) != 0) begin
                        c.read_row    = CUR_ROW_W'($urandom_range(ROWS-1));
                        c.read_column = CUR_COL_W'($urandom_range(COLS-1));
                    end
                    send_cmd(c, 1'b0, '0);
                end
                sent += len;
            end else if (sel < 82) begin
                send_cmd(random_cmd(OP_CLEAR), 1'b0, '0);
                sent++;
            end else begin
                c = random_cmd(2'($urandom_range(3)));
                send_cmd(c, 1'b0, '0);
                if (c.opcode != OP_UNUSED) begin
                    sent++;
                end
            end
        end
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_status_q.size() == 0) begin
                $error("result strobe with no command outstanding");
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                if (o_result.cursor_row_out !== want.cursor_row_out) begin
                    $error("cursor_row_out: expected %0d, got %0d",
                           want.cursor_row_out, o_result.cursor_row_out);
                    mismatch_count++;
                end
                if (o_result.cursor_column_out !== want.cursor_column_out) begin
                    $error("cursor_column_out: expected %0d, got %0d",
                           want.cursor_column_out, o_result.cursor_column_out);
                    mismatch_count++;
                end
                if (o_result.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0b, got %0b",
                           want.scrolled, o_result.scrolled);
                    mismatch_count++;
                end
                if (o_result.cell_char !== want.cell_char) begin
                    $error("cell_char: expected 0x%02h, got 0x%02h",
                           want.cell_char, o_result.cell_char);
                    mismatch_count++;
                end
                if (o_result.cell_color !== want.cell_color) begin
                    $error("cell_color: expected 0x%02h, got 0x%02h",
                           want.cell_color, o_result.cell_color);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] attr_plan [PHASES];
        int         idle_plan [PHASES];

        dir_tab = '{
            '{'{OP_UNUSED, 8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_CLEAR,  8'h00, 5'd0,  7'd0},   1'b1, '{5'd0, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_READ,   8'h00, 5'd0,  7'd0},   1'b1,
              '{5'd0, 7'd0, 1'b0, CHAR_BLANK, COLOR_RESET}},
            '{'{OP_READ,   8'hFF, 5'd24, 7'd79},  1'b1,
              '{5'd0, 7'd0, 1'b0, CHAR_BLANK, COLOR_RESET}},
            '{'{OP_READ,   8'h00, 5'd25, 7'd0},   1'b1, '{5'd0, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_READ,   8'h00, 5'd0,  7'd80},  1'b1, '{5'd0, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_READ,   8'h00, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_WRITE,  8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd1, 1'b0, 8'h00, 8'h00}},
            '{'{OP_WRITE,  8'h00, 5'd0,  7'd0},   1'b1, '{5'd0, 7'd2, 1'b0, 8'h00, 8'h00}},
            '{'{OP_READ,   8'h00, 5'd0,  7'd0},   1'b1,
              '{5'd0, 7'd2, 1'b0, 8'hFF, COLOR_RESET}},
            '{'{OP_READ,   8'h00, 5'd0,  7'd1},   1'b1,
              '{5'd0, 7'd2, 1'b0, 8'h00, COLOR_RESET}},
            '{'{OP_WRITE,  CHAR_NEWLINE, 5'd0, 7'd0}, 1'b1,
              '{5'd1, 7'd0, 1'b0, 8'h00, 8'h00}},
            '{'{OP_WRITE,  CHAR_BLANK, 5'd5, 7'd9},  1'b0, '0},
            '{'{OP_UNUSED, 8'h5A, 5'd5,  7'd7},   1'b0, '0},
            '{'{OP_CLEAR,  8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd1, 7'd1, 1'b0, 8'h00, 8'h00}},
            '{'{OP_READ,   8'h00, 5'd0,  7'd0},   1'b1,
              '{5'd1, 7'd1, 1'b0, CHAR_BLANK, COLOR_RESET}},
            '{'{OP_READ,   8'hAA, 5'd24, 7'd0},   1'b0, '0},
            '{'{OP_WRITE,  8'h7F, 5'd0,  7'd0},   1'b0, '0},
            '{'{OP_READ,   8'h00, 5'd1,  7'd1},   1'b0, '0},
            '{'{OP_WRITE,  8'h80, 5'd16, 7'd64},  1'b0, '0},
            '{'{OP_READ,   8'h55, 5'd1,  7'd2},   1'b0, '0}
        };

        attr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'h0F};
        idle_plan = '{35, 35, 46, 46, 0, 0};

        crs_row   = 0;
        crs_col   = 0;
        text_attr = COLOR_RESET;
        for (int i = 0; i < ROWS*COLS; i++) begin
            screen_mem[i] = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The clear near the top of the table defines every cell before any read.
        sender_idle_pct = 35;
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_cmd(dir_tab[i].cmd, dir_tab[i].fixed_exp, dir_tab[i].want);
        end
        start <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_attr(attr_plan[p]);
            sender_idle_pct = idle_plan[p];
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
